// File: hdl/lpg_pkg.sv
// Package holding the sizes, derived widths and sequencer states of the line pixel generator.
package lpg_pkg;

    // Bits per coordinate axis; the tile spans 2^COORD_BITS pixels on each axis.
    localparam int COORD_BITS = 6;
    // Width of the packed red, green, blue color.
    localparam int COLOR_BITS = 24;
    // Signed error term: it stays within minus one span and three spans.
    localparam int ERR_BITS   = COORD_BITS + 3;

    // One-hot sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

endpackage

// File: hdl/line_pixel_generator_core.sv
// Top level: Bresenham line pixel generator with a setup step and a shared stepping unit.
// A command is captured, the setup step registers the walk state, then the first pixel
// beat is registered. Throughput: one pixel per cycle while the output is not stalled; a
// line of major span S gives S + 1 beats and stalls the input until the last is loaded.
// The single error add, compare and subtract unit in the run state sets the pixel rate.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
module line_pixel_generator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lpg_pkg::COORD_BITS-1:0] i_start_first,
    input  logic [lpg_pkg::COORD_BITS-1:0] i_start_second,
    input  logic [lpg_pkg::COORD_BITS-1:0] i_end_first,
    input  logic [lpg_pkg::COORD_BITS-1:0] i_end_second,
    input  logic [lpg_pkg::COLOR_BITS-1:0] i_color,
    // Pixel channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lpg_pkg::COORD_BITS-1:0] o_pixel_first,
    output logic [lpg_pkg::COORD_BITS-1:0] o_pixel_second,
    output logic [lpg_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                           o_last_pixel
);
    import lpg_pkg::*;

    // Sequencer and captured command.
    t_state                r_state, n_state;
    logic [COORD_BITS-1:0] r_a0, r_b0, r_a1, r_b1;
    logic [COLOR_BITS-1:0] r_color;

    // Line walking state.
    logic [COORD_BITS-1:0]      r_maj_pos, r_min_pos, r_maj_end, r_span;
    logic [COORD_BITS:0]        r_inc;
    logic signed [ERR_BITS-1:0] r_err;
    logic                       r_steep, r_down;

    // Output register.
    logic                  r_o_valid;
    logic [COORD_BITS-1:0] r_o_first, r_o_second;
    logic [COLOR_BITS-1:0] r_o_color;
    logic                  r_o_last;

    logic w_accept;
    logic w_load;
    logic w_last;

    // Setup terms.
    logic [COORD_BITS-1:0] w_da, w_db;
    logic                  w_steep, w_swap;
    logic [COORD_BITS-1:0] w_p0maj, w_p0min, w_p1maj, w_p1min;
    logic [COORD_BITS-1:0] w_maj0, w_min0, w_maj1, w_min1, w_min_span;

    // Step terms.
    logic signed [ERR_BITS-1:0] w_sum, w_err_next;
    logic                       w_over;
    logic [COORD_BITS-1:0]      w_min_next;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign w_load   = (r_state == ST_RUN) && (!r_o_valid || !i_stall);
    assign w_last   = (r_maj_pos == r_maj_end);

    // Setup: choose the major axis and order the endpoints along it.
    always_comb begin
        w_da    = (r_a0 > r_a1) ? (r_a0 - r_a1) : (r_a1 - r_a0);
        w_db    = (r_b0 > r_b1) ? (r_b0 - r_b1) : (r_b1 - r_b0);
        w_steep = (w_da < w_db);
        w_p0maj = w_steep ? r_b0 : r_a0;
        w_p0min = w_steep ? r_a0 : r_b0;
        w_p1maj = w_steep ? r_b1 : r_a1;
        w_p1min = w_steep ? r_a1 : r_b1;
        w_swap  = (w_p0maj > w_p1maj);
        w_maj0  = w_swap ? w_p1maj : w_p0maj;
        w_min0  = w_swap ? w_p1min : w_p0min;
        w_maj1  = w_swap ? w_p0maj : w_p1maj;
        w_min1  = w_swap ? w_p0min : w_p1min;
        w_min_span = (w_min0 > w_min1) ? (w_min0 - w_min1) : (w_min1 - w_min0);
    end

    // Shared stepping unit: add the increment, compare against the span, pull back.
    always_comb begin
        w_sum      = r_err + $signed({2'b00, r_inc});
        w_over     = (w_sum > $signed({3'b000, r_span}));
        w_err_next = w_over ? (w_sum - $signed({2'b00, r_span, 1'b0})) : w_sum;
        if (!w_over) begin
            w_min_next = r_min_pos;
        end else if (r_down) begin
            w_min_next = r_min_pos - COORD_BITS'(1);
        end else begin
            w_min_next = r_min_pos + COORD_BITS'(1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_RUN;
            ST_RUN:   if (w_load && w_last) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Command capture, setup results and the walk along the major axis.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a0    <= i_start_first;
            r_b0    <= i_start_second;
            r_a1    <= i_end_first;
            r_b1    <= i_end_second;
            r_color <= i_color;
        end
        if (r_state == ST_SETUP) begin
            r_steep   <= w_steep;
            r_maj_pos <= w_maj0;
            r_min_pos <= w_min0;
            r_maj_end <= w_maj1;
            r_span    <= w_maj1 - w_maj0;
            r_inc     <= {w_min_span, 1'b0};
            r_down    <= (w_min1 < w_min0);
            r_err     <= '0;
        end else if (w_load && !w_last) begin
            r_maj_pos <= r_maj_pos + COORD_BITS'(1);
            r_min_pos <= w_min_next;
            r_err     <= w_err_next;
        end
    end

    // Output payload, back in the caller's axis order.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_first  <= r_steep ? r_min_pos : r_maj_pos;
            r_o_second <= r_steep ? r_maj_pos : r_min_pos;
            r_o_color  <= r_color;
            r_o_last   <= w_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_pixel_first  = r_o_first;
    assign o_pixel_second = r_o_second;
    assign o_pixel_color  = r_o_color;
    assign o_last_pixel   = r_o_last;

endmodule

// File: hdl/lpg_checker.sv
// Port-level checker for the line pixel generator and its bind to the top level.
module lpg_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [lpg_pkg::COORD_BITS-1:0] i_start_first,
    input logic [lpg_pkg::COORD_BITS-1:0] i_start_second,
    input logic [lpg_pkg::COORD_BITS-1:0] i_end_first,
    input logic [lpg_pkg::COORD_BITS-1:0] i_end_second,
    input logic [lpg_pkg::COLOR_BITS-1:0] i_color,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [lpg_pkg::COORD_BITS-1:0] o_pixel_first,
    input logic [lpg_pkg::COORD_BITS-1:0] o_pixel_second,
    input logic [lpg_pkg::COLOR_BITS-1:0] o_pixel_color,
    input logic                           o_last_pixel
);
    import lpg_pkg::*;

    // A stalled pixel beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_first)
            && $stable(o_pixel_second) && $stable(o_pixel_color) && $stable(o_last_pixel))
        else $error("pixel beat changed while stalled");

    // A command beat closes the input until its line is done.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after a command beat");

    // The input reopens only with the final pixel waiting at the output.
    a_reopen_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_stall) |-> o_valid && o_last_pixel)
        else $error("input reopened without the final pixel");

    // A line does not pause between pixels once the output takes them.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_pixel && !i_stall |=> o_valid)
        else $error("gap inside a line");

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (.*);
